FILE: design/sida_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII block.
`default_nettype none

package sida_pkg;

	localparam int ValueWidth      = 32;
	localparam int NumDigits       = 10;
	localparam int BcdWidth        = 4 * NumDigits;
	localparam int ShiftCountWidth = 5;
	localparam int DigitIdxWidth   = 4;
	localparam int CharWidth       = 6;

	localparam logic [ShiftCountWidth-1:0] LastShift = 5'd31;
	localparam logic [CharWidth-1:0]       CharZero  = 6'd48;
	localparam logic [CharWidth-1:0]       CharMinus = 6'd45;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_LOCATE,
		ST_SIGN,
		ST_DIGITS
	} sida_state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic locate;
		logic emit_sign;
		logic emit_digit;
	} sida_cmd_t;

	typedef struct packed {
		logic shift_done;
		logic negative;
		logic out_free;
		logic last_digit;
	} sida_status_t;

endpackage

`default_nettype wire

FILE: design/sida_datapath.sv
// Datapath: magnitude and BCD shift registers, digit pointer and output register.
`default_nettype none

module sida_datapath
	import sida_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [ValueWidth-1:0] value,
	input  wire sida_cmd_t             cmd,
	output sida_status_t               status,
	output logic [CharWidth-1:0]       character,
	output logic                       last,
	output logic                       char_valid,
	input  wire logic                  char_ready
);

	logic [ValueWidth-1:0]      mag_q;
	logic [BcdWidth-1:0]        bcd_q;
	logic                       neg_q;
	logic [ShiftCountWidth-1:0] cnt_q;
	logic [DigitIdxWidth-1:0]   idx_q;
	logic                       valid_q;
	logic [CharWidth-1:0]       char_q;
	logic                       last_q;

	logic [ValueWidth-1:0]      mag_in;
	logic [BcdWidth-1:0]        bcd_adj;
	logic [DigitIdxWidth-1:0]   lead_idx;
	logic [3:0]                 cur_digit;

	assign mag_in = value[ValueWidth-1] ? (ValueWidth'(0) - value) : value;

	// Add-3 correction on every digit of five or more before each shift.
	always_comb begin
		for (int i = 0; i < NumDigits; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	// Highest nonzero digit; stays at zero when the value is zero.
	always_comb begin
		lead_idx = '0;
		for (int i = 0; i < NumDigits; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0)
				lead_idx = DigitIdxWidth'(i);
		end
	end

	assign cur_digit = bcd_q[{idx_q, 2'b00} +: 4];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= mag_in;
			bcd_q <= '0;
			neg_q <= value[ValueWidth-1];
		end else if (cmd.shift) begin
			mag_q <= {mag_q[ValueWidth-2:0], 1'b0};
			bcd_q <= {bcd_adj[BcdWidth-2:0], mag_q[ValueWidth-1]};
		end
		if (cmd.locate)
			idx_q <= lead_idx;
		else if (cmd.emit_digit)
			idx_q <= idx_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.shift) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			valid_q <= 1'b1;
		end else if (char_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= CharMinus;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= CharZero + CharWidth'(cur_digit);
			last_q <= (idx_q == '0);
		end
	end

	assign status.shift_done = (cnt_q == LastShift);
	assign status.negative   = neg_q;
	assign status.out_free   = !valid_q || char_ready;
	assign status.last_digit = (idx_q == '0);

	assign character  = char_q;
	assign last       = last_q;
	assign char_valid = valid_q;

endmodule

`default_nettype wire

FILE: design/sida_ctrl.sv
// Controller: sequences load, 32 shift steps, digit location and character output.
`default_nettype none

module sida_ctrl
	import sida_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         value_valid,
	output logic              value_ready,
	input  wire sida_status_t status,
	output sida_cmd_t         cmd
);

	sida_state_t state_q;
	sida_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		value_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				value_ready = 1'b1;
				if (value_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONVERT;
				end
			end
			ST_CONVERT: begin
				cmd.shift = 1'b1;
				if (status.shift_done)
					state_d = ST_LOCATE;
			end
			ST_LOCATE: begin
				cmd.locate = 1'b1;
				state_d    = status.negative ? ST_SIGN : ST_DIGITS;
			end
			ST_SIGN: begin
				if (status.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				if (status.out_free) begin
					cmd.emit_digit = 1'b1;
					if (status.last_digit)
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/signed_int_to_decimal_ascii_top.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  value   | value_valid, value_ready, value  | in
//  char    | char_valid, char_ready, character, last | out
//
// A word is loaded, shifted by double-dabble and its leading digit located; then
// one character (1 to 11) goes out per cycle while the output is not stalled.
// The shift count is set by the 32-bit magnitude passing through the BCD register.
// A new word is taken only once the last character of the previous one is in the
// output register. Reset clears the controller and the output valid flag.
// A stalled output simply holds the controller until the register frees up.
`default_nettype none

module signed_int_to_decimal_ascii_top
	import sida_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  value_valid,
	output logic                       value_ready,
	input  wire logic [ValueWidth-1:0] value,
	output logic                       char_valid,
	input  wire logic                  char_ready,
	output logic [CharWidth-1:0]       character,
	output logic                       last
);

	sida_cmd_t    cmd;
	sida_status_t status;

	sida_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.status      (status),
		.cmd         (cmd)
	);

	sida_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.cmd        (cmd),
		.status     (status),
		.character  (character),
		.last       (last),
		.char_valid (char_valid),
		.char_ready (char_ready)
	);

	// A character is written only when the output register is free.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sign || cmd.emit_digit) |-> (!char_valid || char_ready))
		else $error("character written over a stalled word");

	// Accepting a word makes the block busy on the next cycle.
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(value_valid && value_ready) |=> !value_ready)
		else $error("input accepted again right after a load");

	// Commands are mutually exclusive.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.shift, cmd.locate, cmd.emit_sign, cmd.emit_digit}))
		else $error("conflicting datapath commands");

	// The sign is never the last character of a run.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && character == CharMinus) |-> !last)
		else $error("minus sign marked as last");

endmodule

`default_nettype wire
